// ----- hw/rtl/ssye_pkg.sv -----
// ----------------------------------------------------------------------------
// ssye_pkg
// Shared types and constants for the boat speed/yaw Euler step block.
// ----------------------------------------------------------------------------
package ssye_pkg;

    localparam int MUL_AW    = 40;
    localparam int MUL_BW    = 32;
    localparam int MUL_PW    = 64;
    localparam int MUL_NW    = 5;
    localparam int DIV_W     = 26;
    localparam int DIV_STEPS = 24;
    localparam int CFG_AW    = 3;
    localparam int CFG_DW    = 26;

    localparam logic signed [26:0] DEG360 = 27'sd23592960;
    localparam logic signed [26:0] DEG180 = 27'sd11796480;

    typedef enum logic [CFG_AW-1:0] {
        REG_THRUST  = 3'd0,
        REG_LDRAG   = 3'd1,
        REG_QDRAG   = 3'd2,
        REG_STOP    = 3'd3,
        REG_YAWRATE = 3'd4,
        REG_TREF    = 3'd5,
        REG_SLIMIT  = 3'd6
    } t_cfg_reg;

    typedef struct packed {
        logic              start;
        logic [MUL_AW-1:0] a;
        logic [MUL_BW-1:0] b;
        logic [MUL_NW-1:0] n;
    } t_mul_req;

endpackage

// ----- hw/rtl/ship_speed_yaw_euler_step.sv -----
// ----------------------------------------------------------------------------
// ship_speed_yaw_euler_step
// One forward-Euler tick of a boat speed/yaw model per input transaction.
// Products run on the bit-serial multiplier (eight, or nine with the divider
// path, of n = 16, 24 or 31 bits) and the quotient on the restoring divider.
// A zero step or an over-limit stored speed skips them and returns a zeroed, invalid result.
// Throughput: one transaction at a time. Sync active-low reset clears the
// control, speed and heading and loads the register defaults.
// ----------------------------------------------------------------------------
module ship_speed_yaw_euler_step (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [ssye_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  logic [ssye_pkg::CFG_DW-1:0]   i_cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // throttle[15:0], steer[31:16], step_time[55:32]
    input  logic [55:0]                   s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // acceleration[39:0], yaw_rate[64:40], travel[96:65],
    // next_speed[128:97], next_yaw[153:129], zero pad
    output logic [159:0]                  m_axis_tdata,
    // valid_res[0]
    output logic                          m_axis_tuser
);
    import ssye_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_ZERO, S_QC, S_T1, S_T2, S_T3, S_SAT, S_YM, S_DIV,
        S_YF, S_TRV, S_NS, S_NY, S_WRAP, S_SNAP, S_FIN
    } t_state;

    t_state r_state;

    logic [24:0] r_thrust;
    logic [17:0] r_ldrag;
    logic [23:0] r_qdrag;
    logic [21:0] r_stop;
    logic [23:0] r_yrl;
    logic [25:0] r_tref;
    logic [14:0] r_slim;

    logic signed [31:0] r_speed;
    logic signed [24:0] r_heading;
    logic signed [15:0] r_thr;
    logic signed [15:0] r_st;
    logic [23:0]        r_dt;
    logic [30:0]        r_av;
    logic [30:0]        r_qcoef;
    logic signed [63:0] r_acc64;
    logic signed [39:0] r_acc;
    logic [39:0]        r_m;
    logic [24:0]        r_rmag;
    logic signed [31:0] r_travel;
    logic signed [41:0] r_ns;
    logic signed [26:0] r_sum;

    t_mul_req r_mreq;
    logic     r_div_start;
    logic     w_mul_done;
    logic [MUL_PW-1:0] w_prod;
    logic     w_div_done;
    logic [DIV_STEPS-1:0] w_quot;

    logic                r_o_valid;
    logic                r_o_user;
    logic [159:0]        r_o_data;

    logic [31:0]         w_av;
    logic [30:0]         w_lim;
    logic [15:0]         w_thr_mag;
    logic [15:0]         w_st_mag;
    logic [39:0]         w_acc_mag;
    logic signed [24:0]  w_rate;
    logic signed [63:0]  w_pos;
    logic signed [63:0]  w_neg;
    logic signed [63:0]  w_sh;
    logic [41:0]         w_ns_mag;
    logic                w_out_free;
    logic                w_in_acc;

    assign w_av      = r_speed[31] ? 32'(-r_speed) : 32'(r_speed);
    assign w_lim     = {r_slim, 16'b0};
    assign w_thr_mag = r_thr[15] ? 16'(-r_thr) : 16'(r_thr);
    assign w_st_mag  = r_st[15] ? 16'(-r_st) : 16'(r_st);
    assign w_acc_mag = r_acc[39] ? 40'(-r_acc) : 40'(r_acc);
    assign w_rate    = r_st[15] ? -$signed(r_rmag) : $signed(r_rmag);
    assign w_pos     = $signed(w_prod);
    assign w_neg     = -$signed(w_prod);
    assign w_sh      = r_acc64 >>> 24;
    assign w_ns_mag  = r_ns[41] ? 42'(-r_ns) : 42'(r_ns);
    assign w_out_free = !r_o_valid || m_axis_tready;
    assign w_in_acc  = s_axis_tvalid && s_axis_tready;

    ssye_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_mreq),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    ssye_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_av[DIV_W-1:0]),
        .i_den   (r_tref),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thrust <= 25'd6553600;
            r_ldrag  <= 18'd32768;
            r_qdrag  <= 24'd0;
            r_stop   <= 22'd65536;
            r_yrl    <= 24'd1966080;
            r_tref   <= 26'd6553600;
            r_slim   <= 15'd5000;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                REG_THRUST:  r_thrust <= i_cfg_data[24:0];
                REG_LDRAG:   r_ldrag  <= i_cfg_data[17:0];
                REG_QDRAG:   r_qdrag  <= i_cfg_data[23:0];
                REG_STOP:    r_stop   <= i_cfg_data[21:0];
                REG_YAWRATE: r_yrl    <= i_cfg_data[23:0];
                REG_TREF:    r_tref   <= i_cfg_data[25:0];
                REG_SLIMIT:  r_slim   <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_speed      <= '0;
            r_heading    <= '0;
            r_mreq.start <= 1'b0;
            r_div_start  <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_mreq.start <= 1'b0;
            r_div_start  <= 1'b0;
            if (m_axis_tvalid && m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_thr <= s_axis_tdata[15:0];
                        r_st  <= s_axis_tdata[31:16];
                        r_dt  <= s_axis_tdata[55:32];
                        r_av  <= w_av[30:0];
                        if (s_axis_tdata[55:32] == 24'd0 || w_av > {1'b0, w_lim}) begin
                            r_state <= S_ZERO;
                        end else begin
                            r_mreq <= '{1'b1, MUL_AW'(r_qdrag), {1'b0, w_av[30:0]},
                                       MUL_NW'(31)};
                            r_state <= S_QC;
                        end
                    end
                end
                S_ZERO: begin
                    if (w_out_free) begin
                        r_speed   <= '0;
                        r_heading <= '0;
                        r_o_valid <= 1'b1;
                        r_o_user  <= 1'b0;
                        r_o_data  <= '0;
                        r_state   <= S_IDLE;
                    end
                end
                S_QC: begin
                    if (w_mul_done) begin
                        r_qcoef <= w_prod[54:24];
                        r_mreq  <= '{1'b1, MUL_AW'(r_thrust), MUL_BW'(w_thr_mag),
                                    MUL_NW'(16)};
                        r_state <= S_T1;
                    end
                end
                S_T1: begin
                    if (w_mul_done) begin
                        r_acc64 <= r_thr[15] ? -$signed({w_prod[54:0], 9'b0})
                                             : $signed({w_prod[54:0], 9'b0});
                        r_mreq  <= '{1'b1, MUL_AW'(r_ldrag), {1'b0, r_av}, MUL_NW'(31)};
                        r_state <= S_T2;
                    end
                end
                S_T2: begin
                    if (w_mul_done) begin
                        r_acc64 <= r_speed[31] ? r_acc64 + $signed({w_prod[55:0], 8'b0})
                                               : r_acc64 - $signed({w_prod[55:0], 8'b0});
                        r_mreq  <= '{1'b1, MUL_AW'(r_qcoef), {1'b0, r_av}, MUL_NW'(31)};
                        r_state <= S_T3;
                    end
                end
                S_T3: begin
                    if (w_mul_done) begin
                        r_acc64 <= r_speed[31] ? r_acc64 + w_pos : r_acc64 - w_pos;
                        r_state <= S_SAT;
                    end
                end
                S_SAT: begin
                    if (w_sh[63:39] != {25{w_sh[39]}}) begin
                        r_acc <= w_sh[63] ? 40'sh80_0000_0000 : 40'sh7F_FFFF_FFFF;
                    end else begin
                        r_acc <= w_sh[39:0];
                    end
                    r_mreq  <= '{1'b1, MUL_AW'(r_yrl), MUL_BW'(w_st_mag), MUL_NW'(16)};
                    r_state <= S_YM;
                end
                S_YM: begin
                    if (w_mul_done) begin
                        r_m <= w_prod[39:0];
                        if (r_av >= {5'b0, r_tref}) begin
                            r_rmag  <= w_prod[39:15];
                            r_mreq  <= '{1'b1, MUL_AW'(r_av), MUL_BW'(r_dt), MUL_NW'(24)};
                            r_state <= S_TRV;
                        end else begin
                            r_div_start <= 1'b1;
                            r_state     <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_mreq  <= '{1'b1, r_m, MUL_BW'(w_quot), MUL_NW'(24)};
                        r_state <= S_YF;
                    end
                end
                S_YF: begin
                    if (w_mul_done) begin
                        r_rmag  <= w_prod[63:39];
                        r_mreq  <= '{1'b1, MUL_AW'(r_av), MUL_BW'(r_dt), MUL_NW'(24)};
                        r_state <= S_TRV;
                    end
                end
                S_TRV: begin
                    if (w_mul_done) begin
                        r_travel <= r_speed[31] ? 32'(w_neg >>> 24) : 32'(w_pos >>> 24);
                        r_mreq   <= '{1'b1, w_acc_mag, MUL_BW'(r_dt), MUL_NW'(24)};
                        r_state  <= S_NS;
                    end
                end
                S_NS: begin
                    if (w_mul_done) begin
                        r_ns <= {{10{r_speed[31]}}, r_speed}
                              + (r_acc[39] ? 42'(w_neg >>> 24) : 42'(w_pos >>> 24));
                        r_mreq  <= '{1'b1, MUL_AW'(r_rmag), MUL_BW'(r_dt), MUL_NW'(24)};
                        r_state <= S_NY;
                    end
                end
                S_NY: begin
                    if (w_mul_done) begin
                        r_sum <= {{2{r_heading[24]}}, r_heading}
                               + (r_st[15] ? 27'(w_neg >>> 24) : 27'(w_pos >>> 24));
                        r_state <= S_WRAP;
                    end
                end
                S_WRAP: begin
                    if (r_sum < 0) begin
                        r_sum <= r_sum + DEG360;
                    end else if (r_sum >= DEG360) begin
                        r_sum <= r_sum - DEG360;
                    end else begin
                        if (r_sum > DEG180) begin
                            r_sum <= r_sum - DEG360;
                        end
                        r_state <= S_SNAP;
                    end
                end
                S_SNAP: begin
                    if (r_thr == 16'sd0 && w_ns_mag <= 42'(r_stop)) begin
                        r_ns <= '0;
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_o_valid <= 1'b1;
                        if (w_ns_mag <= 42'(w_lim)) begin
                            r_speed   <= r_ns[31:0];
                            r_heading <= r_sum[24:0];
                            r_o_user  <= 1'b1;
                            r_o_data  <= {6'b0, r_sum[24:0], r_ns[31:0], r_travel,
                                          w_rate, r_acc};
                        end else begin
                            r_speed  <= '0;
                            r_o_user <= 1'b0;
                            r_o_data <= {6'b0, r_heading, 32'b0, r_travel, w_rate, r_acc};
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tuser  = r_o_user;

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_heading <= $signed(DEG180[24:0])) && (r_heading > -$signed(DEG180[24:0])))
        else $error("heading out of range");

    a_invalid_speed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[128:97] == 32'd0))
        else $error("invalid result with nonzero speed");

    a_div_fraction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_start |-> (r_av < {5'b0, r_tref}))
        else $error("divider started with speed above reference");

endmodule

// ----- hw/rtl/ssye_mul.sv -----
// ----------------------------------------------------------------------------
// ssye_mul
// Bit-serial unsigned multiplier, MSB first, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ssye_mul (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ssye_pkg::t_mul_req           i_req,
    output logic                         o_done,
    output logic [ssye_pkg::MUL_PW-1:0]  o_prod
);
    import ssye_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [MUL_NW-1:0] r_idx;
    logic [MUL_AW-1:0] r_a;
    logic [MUL_BW-1:0] r_b;
    logic [MUL_PW-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_idx  <= i_req.n - MUL_NW'(1);
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_acc  <= '0;
            end else if (r_busy) begin
                r_acc <= {r_acc[MUL_PW-2:0], 1'b0}
                       + (r_b[r_idx] ? MUL_PW'(r_a) : MUL_PW'(0));
                if (r_idx == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_idx <= r_idx - MUL_NW'(1);
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ----- hw/rtl/ssye_div.sv -----
// ----------------------------------------------------------------------------
// ssye_div
// Restoring fraction divider: num/den with num < den, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module ssye_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [ssye_pkg::DIV_W-1:0]     i_num,
    input  logic [ssye_pkg::DIV_W-1:0]     i_den,
    output logic                           o_done,
    output logic [ssye_pkg::DIV_STEPS-1:0] o_quot
);
    import ssye_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [4:0]           r_cnt;
    logic [DIV_W:0]       r_rem;
    logic [DIV_W-1:0]     r_den;
    logic [DIV_STEPS-1:0] r_quot;
    logic [DIV_W:0]       w_rem2;
    logic                 w_ge;

    assign w_rem2 = {r_rem[DIV_W-1:0], 1'b0};
    assign w_ge   = (w_rem2 >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(DIV_STEPS - 1);
                r_rem  <= {1'b0, i_num};
                r_den  <= i_den;
                r_quot <= '0;
            end else if (r_busy) begin
                r_rem  <= w_ge ? (w_rem2 - {1'b0, r_den}) : w_rem2;
                r_quot <= {r_quot[DIV_STEPS-2:0], w_ge};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 5'd1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
